// ----- hw/rtl/dfl_pkg.sv -----
// shared types, codes and default sizes for the decision forest leaf index block
`default_nettype none

package dfl_pkg;

    // default sizes
    localparam int DFL_TREE_COUNT   = 8;
    localparam int DFL_TREE_DEPTH   = 4;
    localparam int DFL_NUM_FEATURES = 512;
    localparam int DFL_QUEUE_DEPTH  = 2;

    localparam int FEAT_IDX_W = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // command function codes
    localparam logic [1:0] FUNC_NODE_WR = 2'd0;
    localparam logic [1:0] FUNC_FEAT_WR = 2'd1;
    localparam logic [1:0] FUNC_EVAL    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LANDMARK = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 4'd1;

    localparam logic [3:0] ACTIVE_TREES_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]            func;
        logic [2:0]            tree;
        logic [3:0]            node;
        logic [FEAT_IDX_W-1:0] feature_index;
        logic                  no_split;
        logic signed [15:0]    value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  tree_number;
        logic [3:0]  leaf;
        logic [15:0] binary_index;
        logic        last_tree;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [7:0] landmark_index;
        logic [3:0] active_trees;
    } cfg_regs_t;

    typedef enum logic [1:0] {
        OP_NODE_WR,
        OP_FEAT_WR,
        OP_EVAL
    } op_t;

    typedef struct packed {
        op_t  op;
        cmd_t cmd;
    } job_t;

    typedef struct packed {
        logic [FEAT_IDX_W-1:0] feature_index;
        logic                  no_split;
        logic signed [15:0]    threshold;
    } node_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dfl_ifs.sv -----
// valid/ready channel interfaces for commands, results and configuration writes
`default_nettype none

interface dfl_cmd_if import dfl_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dfl_res_if import dfl_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dfl_cfg_if import dfl_pkg::*; ();
    logic    valid;
    logic    ready;
    cfg_wr_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dfl_front.sv -----
// front end: takes commands, classifies them and drops the ones with no effect
`default_nettype none

module dfl_front import dfl_pkg::*; #(
    parameter int TREE_COUNT   = DFL_TREE_COUNT,
    parameter int TREE_DEPTH   = DFL_TREE_DEPTH,
    parameter int NUM_FEATURES = DFL_NUM_FEATURES
) (
    dfl_cmd_if.sink    cmd,
    output logic       push_valid,
    output job_t       push_job,
    input  logic       push_ready
);

    localparam int INNER = (1 << TREE_DEPTH) - 1;

    logic keep;

    always_comb
    begin
        keep         = 1'b0;
        push_job.cmd = cmd.payload;
        push_job.op  = OP_EVAL;
        case (cmd.payload.func)
            FUNC_NODE_WR:
            begin
                push_job.op = OP_NODE_WR;
                keep = (32'(cmd.payload.tree) < TREE_COUNT) && (32'(cmd.payload.node) < INNER);
            end
            FUNC_FEAT_WR:
            begin
                push_job.op = OP_FEAT_WR;
                keep = 32'(cmd.payload.feature_index) < NUM_FEATURES;
            end
            FUNC_EVAL:
            begin
                push_job.op = OP_EVAL;
                keep = 1'b1;
            end
            default:
            begin
                // unused function code: transfer is taken and discarded
                keep = 1'b0;
            end
        endcase
    end

    assign cmd.ready  = push_ready;
    assign push_valid = cmd.valid && keep;

endmodule

`default_nettype wire

// ----- hw/rtl/dfl_queue.sv -----
// short job queue between the front end and the execution back end
`default_nettype none

module dfl_queue import dfl_pkg::*; #(
    parameter int DEPTH = DFL_QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dfl_back.sv -----
// back end: node and feature memories, tree walk sequencer and result register
`default_nettype none

module dfl_back import dfl_pkg::*; #(
    parameter int TREE_COUNT   = DFL_TREE_COUNT,
    parameter int TREE_DEPTH   = DFL_TREE_DEPTH,
    parameter int NUM_FEATURES = DFL_NUM_FEATURES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_regs_t  cfg_regs,
    input  logic       job_valid,
    input  job_t       job,
    output logic       pop,
    dfl_res_if.source  result
);

    localparam int INNER = (1 << TREE_DEPTH) - 1;
    localparam int TABLE = TREE_COUNT * INNER;
    localparam int NA_W  = (TABLE > 1) ? $clog2(TABLE) : 1;
    localparam int FA_W  = $clog2(NUM_FEATURES);
    localparam int PW    = TREE_DEPTH + 1;
    localparam int LV_W  = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
    localparam int NN_W  = $clog2(TREE_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEAT,
        S_STEP,
        S_HOLD
    } state_t;

    node_entry_t        node_mem [TABLE];
    logic signed [15:0] feat_mem [NUM_FEATURES];
    node_entry_t        node_q;
    logic signed [15:0] feat_q;

    state_t                state_reg, state_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [LV_W-1:0]       level_reg, level_next;
    logic [NN_W-1:0]       tree_reg, tree_next;
    logic [NN_W-1:0]       n_reg, n_next;
    logic [NA_W-1:0]       base_reg, base_next;
    logic [15:0]           slot_reg, slot_next;
    logic [TREE_DEPTH-1:0] leaf_reg, leaf_next;
    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;

    logic                      node_we, node_re, feat_we, feat_re;
    logic [NA_W-1:0]           node_waddr, node_raddr;
    logic [FA_W-1:0]           feat_waddr, feat_raddr;
    logic [FA_W+FEAT_IDX_W-1:0] feat_wext, feat_rext;
    node_entry_t               node_wdata;
    logic [NN_W-1:0]           n_sat;
    logic                      split_ok, go_right;
    logic [PW-1:0]             pos_step, leaf_diff;
    logic [TREE_DEPTH-1:0]     leaf_step, leaf_val;
    logic [TREE_DEPTH+3:0]     leaf_ext;
    logic [NN_W+2:0]           tree_ext;
    logic [15+TREE_DEPTH:0]    bsum;
    logic                      out_free, finish, res_load, last;

    // memory addresses and write data
    assign node_waddr = NA_W'(32'(job.cmd.tree) * INNER + 32'(job.cmd.node));
    assign node_wdata = '{feature_index: job.cmd.feature_index,
                          no_split:      job.cmd.no_split,
                          threshold:     job.cmd.value};
    assign feat_wext  = {{FA_W{1'b0}}, job.cmd.feature_index};
    assign feat_waddr = feat_wext[FA_W-1:0];
    assign feat_rext  = {{FA_W{1'b0}}, node_q.feature_index};
    assign feat_raddr = feat_rext[FA_W-1:0];

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_q <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (feat_we)
        begin
            feat_mem[feat_waddr] <= job.cmd.value;
        end
        if (feat_re)
        begin
            feat_q <= feat_mem[feat_raddr];
        end
    end

    // tree count saturates at the forest size
    assign n_sat = (32'(cfg_regs.active_trees) > TREE_COUNT) ? NN_W'(TREE_COUNT)
                                                              : NN_W'(cfg_regs.active_trees);

    // one level of descent
    assign split_ok  = !node_q.no_split && (32'(node_q.feature_index) < NUM_FEATURES);
    assign go_right  = split_ok && ($signed(feat_q) >= $signed(node_q.threshold));
    assign pos_step  = PW'({pos_reg, 1'b0}) + PW'(1) + PW'(go_right);
    assign leaf_diff = pos_step - PW'(INNER);
    assign leaf_step = leaf_diff[TREE_DEPTH-1:0];

    assign leaf_val = (state_reg == S_HOLD) ? leaf_reg : leaf_step;
    assign leaf_ext = {4'b0, leaf_val};
    assign tree_ext = {3'b0, tree_reg};
    assign bsum     = {slot_reg, {TREE_DEPTH{1'b0}}} + (16 + TREE_DEPTH)'(leaf_val)
                    + (16 + TREE_DEPTH)'(1);
    assign last     = (tree_reg + NN_W'(1)) == n_reg;
    assign out_free = !res_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        level_next     = level_reg;
        tree_next      = tree_reg;
        n_next         = n_reg;
        base_next      = base_reg;
        slot_next      = slot_reg;
        leaf_next      = leaf_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        node_we        = 1'b0;
        feat_we        = 1'b0;
        node_re        = 1'b0;
        feat_re        = 1'b0;
        node_raddr     = base_reg;
        finish         = 1'b0;
        res_load       = 1'b0;

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    pop = 1'b1;
                    case (job.op)
                        OP_NODE_WR:
                        begin
                            node_we = 1'b1;
                        end
                        OP_FEAT_WR:
                        begin
                            feat_we = 1'b1;
                        end
                        OP_EVAL:
                        begin
                            if (n_sat != '0)
                            begin
                                n_next     = n_sat;
                                tree_next  = '0;
                                base_next  = '0;
                                pos_next   = '0;
                                level_next = '0;
                                slot_next  = 16'(cfg_regs.landmark_index) * 16'(n_sat);
                                node_re    = 1'b1;
                                node_raddr = '0;
                                state_next = S_FEAT;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            S_FEAT:
            begin
                feat_re    = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (level_reg == LV_W'(TREE_DEPTH - 1))
                begin
                    leaf_next = leaf_step;
                    finish    = 1'b1;
                end
                else
                begin
                    pos_next   = pos_step;
                    level_next = level_reg + LV_W'(1);
                    node_re    = 1'b1;
                    node_raddr = base_reg + NA_W'(pos_step);
                    state_next = S_FEAT;
                end
            end
            S_HOLD:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // leaf reached: into the result register once free, then next root or idle
        if (finish)
        begin
            if (out_free)
            begin
                res_load                = 1'b1;
                res_valid_next          = 1'b1;
                res_next.tree_number    = tree_ext[2:0];
                res_next.leaf           = leaf_ext[3:0];
                res_next.binary_index   = bsum[15:0];
                res_next.last_tree      = last;
                if (last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    tree_next  = tree_reg + NN_W'(1);
                    base_next  = base_reg + NA_W'(INNER);
                    slot_next  = slot_reg + 16'd1;
                    pos_next   = '0;
                    level_next = '0;
                    node_re    = 1'b1;
                    node_raddr = base_reg + NA_W'(INNER);
                    state_next = S_FEAT;
                end
            end
            else
            begin
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            level_reg     <= '0;
            tree_reg      <= '0;
            n_reg         <= '0;
            base_reg      <= '0;
            slot_reg      <= '0;
            leaf_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            level_reg     <= level_next;
            tree_reg      <= tree_next;
            n_reg         <= n_next;
            base_reg      <= base_next;
            slot_reg      <= slot_next;
            leaf_reg      <= leaf_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

    // feature read always follows a fresh node read
    a_node_before_feat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FEAT) |-> $past(node_re))
        else $error("feature read without a preceding node read");

    a_tree_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (tree_reg < n_reg))
        else $error("tree counter beyond active tree count");

    a_pos_inner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FEAT) |-> (32'(pos_reg) < INNER))
        else $error("walk position left the inner nodes");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_next.last_tree) |=> (state_reg == S_IDLE))
        else $error("walk continued after the last tree");

endmodule

`default_nettype wire

// ----- hw/rtl/decision_forest_leaf_index.sv -----
// top level of the decision forest leaf index block
//
//  channel | role   | handshake          | payload
//  cmd     | sink   | valid/ready        | func tree node feature_index no_split value
//  result  | source | valid/ready        | tree_number leaf binary_index last_tree
//  cfg     | sink   | valid/ready (ready | index data
//          |        | always high)       |
//
// node and feature writes are done by the back end from its idle state
// an evaluate walks each of the n active trees from root to leaf in turn, one result per tree:
// each level is a node table read followed by a dependent feature store read
// commands keep transferring into the job queue while the back end walks trees, until the queue is full
// a stalled result register holds the walk at the reached leaf
// reset clears control and the config registers; node and feature memories are not cleared
`default_nettype none

module decision_forest_leaf_index import dfl_pkg::*; #(
    parameter int TREE_COUNT   = DFL_TREE_COUNT,
    parameter int TREE_DEPTH   = DFL_TREE_DEPTH,
    parameter int NUM_FEATURES = DFL_NUM_FEATURES,
    parameter int QUEUE_DEPTH  = DFL_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    dfl_cmd_if.sink   cmd,
    dfl_res_if.source result,
    dfl_cfg_if.sink   cfg
);

    cfg_regs_t cfg_reg;
    logic      push_valid;
    logic      push_ready;
    job_t      push_job;
    logic      job_valid;
    logic      pop;
    job_t      job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.landmark_index <= '0;
            cfg_reg.active_trees   <= ACTIVE_TREES_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                CFG_LANDMARK:
                begin
                    cfg_reg.landmark_index <= cfg.payload.data[7:0];
                end
                CFG_ACTIVE:
                begin
                    cfg_reg.active_trees <= cfg.payload.data[3:0];
                end
                default:
                begin
                    // writes beyond the register list are dropped
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    dfl_front #(
        .TREE_COUNT   (TREE_COUNT),
        .TREE_DEPTH   (TREE_DEPTH),
        .NUM_FEATURES (NUM_FEATURES)
    ) u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    dfl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (job_valid),
        .pop        (pop),
        .pop_job    (job)
    );

    dfl_back #(
        .TREE_COUNT   (TREE_COUNT),
        .TREE_DEPTH   (TREE_DEPTH),
        .NUM_FEATURES (NUM_FEATURES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
